// File: rtl/core/bss_pkg.sv
package bss_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // Request and result field widths
  localparam int ACT_W   = 3;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  // Position compare width: one bit above the position field so that a
  // length of CAPACITY (up to 256) compares cleanly.
  localparam int CMP_W   = POS_W + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_PREPEND = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_REPLACE = 3'd4,
    ACT_READ    = 3'd5
  } bss_act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } bss_status_t;

  // Per-request control broadcast to every cell
  typedef struct packed {
    logic             ins_en;
    logic [CMP_W-1:0] ins_pos;
    logic             rem_en;
    logic             wr_en;
    logic             rd_en;
    logic [POS_W-1:0] pos;
  } bss_ctl_t;

endpackage

// File: rtl/core/bounded_sequence_store.sv
// The result is registered from its request when that request is accepted.
// Throughput: one request per cycle; all cells shift, match and write in
// the same cycle, so the next request needs nothing from a later edge.
// A waiting result holds off new requests (req_stall) until it is taken.
// Reset (rst, synchronous, active high) clears the length and the result
// valid; cell contents are not cleared and only words below the length are read.
module bounded_sequence_store
  import bss_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [ACT_W-1:0]   action,
  input  logic [POS_W-1:0]   position,
  input  logic [VALUE_W-1:0] value,
  // result channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [VALUE_W-1:0] read_value,
  output logic [STAT_W-1:0]  status,
  output logic [COUNT_W-1:0] count,
  output logic               is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);

  // Stored length
  logic [CW-1:0]         fill;
  logic [CW-1:0]         fill_next;

  logic                  req_acc;
  bss_act_t              act;
  logic [WORD_WIDTH-1:0] word_in;
  logic [CMP_W-1:0]      fill_ext;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      ins_pos;
  logic                  is_full;
  logic                  ins_ok;
  logic                  rem_ok;
  logic                  wr_ok;
  logic                  rd_ok;
  logic                  found;
  bss_status_t           stat_next;
  bss_ctl_t              ctl;

  // Cell chain wiring: words, first-match token and read bus
  logic [WORD_WIDTH-1:0] cell_word  [CAPACITY];
  logic                  found_link [CAPACITY+1];
  logic [WORD_WIDTH-1:0] rd_link    [CAPACITY+1];

  // A held result blocks new requests until taken
  assign req_stall = rsp_valid & rsp_stall;
  assign req_acc   = req_valid & ~req_stall;

  assign act      = bss_act_t'(action);
  assign word_in  = WORD_WIDTH'(value);
  assign fill_ext = CMP_W'(fill);
  assign pos_ext  = {1'b0, position};
  assign is_full  = (fill == CW'(CAPACITY));
  assign found    = found_link[CAPACITY];

  // Decode: status and which operation commits
  always_comb begin
    ins_pos   = pos_ext;
    ins_ok    = 1'b0;
    rem_ok    = 1'b0;
    wr_ok     = 1'b0;
    rd_ok     = 1'b0;
    stat_next = ST_OK;
    unique case (act)
      ACT_APPEND, ACT_PREPEND, ACT_INSERT: begin
        if (act == ACT_APPEND) begin
          ins_pos = fill_ext;
        end else if (act == ACT_PREPEND) begin
          ins_pos = '0;
        end
        // range is checked before fullness
        if (ins_pos > fill_ext) begin
          stat_next = ST_RANGE;
        end else if (is_full) begin
          stat_next = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (found) begin
          rem_ok = 1'b1;
        end else begin
          stat_next = ST_NOT_FOUND;
        end
      end
      ACT_REPLACE: begin
        if (pos_ext < fill_ext) begin
          wr_ok = 1'b1;
        end else begin
          stat_next = ST_RANGE;
        end
      end
      ACT_READ: begin
        if (pos_ext < fill_ext) begin
          rd_ok = 1'b1;
        end else begin
          stat_next = ST_RANGE;
        end
      end
      default: begin
        // unused codes: no effect, status ok
        stat_next = ST_OK;
      end
    endcase
  end

  always_comb begin
    if (ins_ok) begin
      fill_next = fill + CW'(1);
    end else if (rem_ok) begin
      fill_next = fill - CW'(1);
    end else begin
      fill_next = fill;
    end
  end

  // Broadcast control; cell writes only on an accepted request. The length
  // goes to the cells on its own wire since the match chain feeds rem_en.
  always_comb begin
    ctl.ins_en  = req_acc & ins_ok;
    ctl.ins_pos = ins_pos;
    ctl.rem_en  = req_acc & rem_ok;
    ctl.wr_en   = req_acc & wr_ok;
    ctl.rd_en   = rd_ok;
    ctl.pos     = position;
  end

  assign found_link[0] = 1'b0;
  assign rd_link[0]    = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;

    // Head takes no left neighbor (that input never gets selected); the tail
    // takes its own word in place of a right one.
    if (i == 0) begin : g_head
      assign left_w = word_in;
    end else begin : g_left
      assign left_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = cell_word[i];
    end else begin : g_right
      assign right_w = cell_word[i+1];
    end

    bss_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .fill      (fill_ext),
      .word_in   (word_in),
      .left      (left_w),
      .right     (right_w),
      .found_in  (found_link[i]),
      .found_out (found_link[i+1]),
      .rd_in     (rd_link[i]),
      .rd_out    (rd_link[i+1]),
      .word      (cell_word[i])
    );
  end

  // Length and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_acc) begin
        fill      <= fill_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      read_value <= VALUE_W'(rd_link[CAPACITY]);
      status     <= stat_next;
      count      <= COUNT_W'(fill_next);
      is_empty   <= (fill_next == '0);
    end
  end

endmodule

// File: rtl/core/bss_cell.sv
module bss_cell
  import bss_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  bss_ctl_t              ctl,
  input  logic [CMP_W-1:0]      fill,
  input  logic [WORD_WIDTH-1:0] word_in,
  input  logic [WORD_WIDTH-1:0] left,
  input  logic [WORD_WIDTH-1:0] right,
  input  logic                  found_in,
  output logic                  found_out,
  input  logic [WORD_WIDTH-1:0] rd_in,
  output logic [WORD_WIDTH-1:0] rd_out,
  output logic [WORD_WIDTH-1:0] word
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [WORD_WIDTH-1:0] word_next;
  logic                  sel;
  logic                  live;
  logic                  match;

  assign sel       = ({1'b0, ctl.pos} == MY_IDX);
  assign live      = (MY_IDX < fill);
  assign match     = live && (word == word_in);
  assign found_out = found_in | match;
  assign rd_out    = rd_in | ((ctl.rd_en && sel) ? word : '0);

  // Insert shifts toward the tail, remove pulls toward the head from the
  // first match onward, and replace writes the addressed cell.
  always_comb begin
    priority if (ctl.ins_en && (MY_IDX > ctl.ins_pos)) begin
      word_next = left;
    end else if (ctl.ins_en && (MY_IDX == ctl.ins_pos)) begin
      word_next = word_in;
    end else if (ctl.rem_en && found_out) begin
      word_next = right;
    end else if (ctl.wr_en && sel) begin
      word_next = word_in;
    end else begin
      word_next = word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// File: rtl/core/bss_checker.sv
module bss_checker
  import bss_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic [VALUE_W-1:0] read_value,
  input logic [STAT_W-1:0]  status,
  input logic [COUNT_W-1:0] count,
  input logic               is_empty
);

  // A result held under stall keeps its contents
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_value) && $stable(status)
      && $stable(count) && $stable(is_empty))
    else $error("result changed while stalled");

  // Only a successful read carries a nonzero word
  a_rd_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (read_value != '0) |-> (status == ST_OK))
    else $error("read data on failed request");

  // Full is only reported at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> (count == COUNT_W'(CAPACITY)))
    else $error("full reported below capacity");

  // Empty flag agrees with the length
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> (count == '0))
    else $error("empty flag with nonzero length");

  // An accepted request always yields a result on the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("accepted request produced no result");

endmodule

bind bounded_sequence_store bss_checker #(.CAPACITY(CAPACITY)) u_bss_checker (.*);
